[sv/crc32tg_pkg.sv]
// Shared types, constants and the byte-wise CRC step for the CRC-32 text-guess core.
package crc32tg_pkg;

   localparam int COUNT_BITS = 32;

   typedef logic [7:0]            byte_type;
   typedef logic [31:0]           crc_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // Reflected form of 0x04C11DB7, bits taken LSB first
   localparam crc_type  CRC_POLY_REFLECTED = 32'hEDB8_8320;
   localparam crc_type  CRC_INIT           = 32'hFFFF_FFFF;
   localparam crc_type  CRC_XOR_OUT        = 32'hFFFF_FFFF;

   // Bytes below TEXT_LOW or at TEXT_HIGH and above count as binary
   localparam byte_type TEXT_LOW           = 8'd7;
   localparam byte_type TEXT_HIGH          = 8'd128;

   localparam int       GUESS_SHIFT        = 2;

   // One pipeline step handed to the state-holding units
   typedef struct packed {
      logic     advance;
      logic     first;
      byte_type data;
   } step_type;

   function automatic crc_type crc_byte(crc_type crc_in, byte_type data);
      crc_type crc;
      crc = crc_in ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY_REFLECTED;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

[sv/crc32tg_if.sv]
// Valid/ready channel interfaces for the request and response words.
interface crc32tg_req_if;
   logic                valid;
   logic                ready;
   crc32tg_pkg::byte_type data_byte;
   logic                first_byte;
   logic                last_byte;

   modport source (output valid, output data_byte, output first_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                   output ready);
endinterface

interface crc32tg_rsp_if;
   logic                 valid;
   logic                 ready;
   crc32tg_pkg::crc_type crc_value;
   logic                 looks_binary;

   modport source (output valid, output crc_value, output looks_binary, input ready);
   modport sink   (input valid, input crc_value, input looks_binary, output ready);
endinterface

[sv/crc32_with_text_guess_core.sv]
// Top level of the streaming CRC-32 core with a text-or-binary guess.
// Takes one message byte per request word, flagged first and/or last, and keeps a
// reflected CRC-32 (poly 0x04C11DB7, init all ones, final inversion) plus saturating
// counts of binary bytes (0..6, 128..255) and text bytes (7..127). A word marked last
// yields one response word: the inverted CRC and looks_binary, set when the binary
// count exceeds a quarter of the text count. Other bytes yield nothing. A byte without
// first carries on the current message, even after a last byte. Throughput is one byte
// per cycle while no last byte stalls. A last byte, once accepted, is held in the input
// register; when it advances, the CRC/counter update is loaded into the response
// register, which drives the response word. The request side stalls only when a last
// byte waits for a response register that is still held.
module crc32_with_text_guess_core (
   input  logic               clock,
   input  logic               reset,
   crc32tg_req_if.sink        req_if,
   crc32tg_rsp_if.source      rsp_if
);

   // input register
   logic                  s1_valid_ff, s1_valid_in;
   crc32tg_pkg::byte_type s1_data_ff;
   logic                  s1_first_ff;
   logic                  s1_last_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   crc32tg_pkg::crc_type  rsp_crc_ff;
   logic                  rsp_binary_ff;

   logic                  s1_advance;
   logic                  rsp_load;
   logic                  req_take;
   crc32tg_pkg::step_type step;
   crc32tg_pkg::crc_type  crc_next;
   logic                  looks_binary_next;

   // Non-last bytes always move on; a last byte needs a free (or draining) response slot
   always_comb begin
      s1_advance = s1_valid_ff &&
                   (!s1_last_ff || !rsp_valid_ff || rsp_if.ready);
      rsp_load   = s1_advance && s1_last_ff;
      req_take   = req_if.valid && req_if.ready;
   end

   assign req_if.ready = !s1_valid_ff || s1_advance;

   always_comb begin
      step.advance = s1_advance;
      step.first   = s1_first_ff;
      step.data    = s1_data_ff;
   end

   always_comb begin
      s1_valid_in = req_if.ready ? req_if.valid : s1_valid_ff;
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   crc32tg_crc u_crc (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .crc_next (crc_next)
   );

   crc32tg_guess u_guess (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .looks_binary_next (looks_binary_next)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff  <= req_if.data_byte;
         s1_first_ff <= req_if.first_byte;
         s1_last_ff  <= req_if.last_byte;
      end
      if (rsp_load) begin
         rsp_crc_ff    <= crc_next ^ crc32tg_pkg::CRC_XOR_OUT;
         rsp_binary_ff <= looks_binary_next;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.crc_value    = rsp_crc_ff;
   assign rsp_if.looks_binary = rsp_binary_ff;

endmodule

[sv/crc32tg_crc.sv]
// Running reflected CRC-32 register with its one-byte update.
module crc32tg_crc (
   input  logic                  clock,
   input  logic                  reset,
   input  crc32tg_pkg::step_type step,
   output crc32tg_pkg::crc_type  crc_next
);

   crc32tg_pkg::crc_type crc_ff;
   crc32tg_pkg::crc_type crc_in;
   crc32tg_pkg::crc_type crc_base;

   always_comb begin
      crc_base = step.first ? crc32tg_pkg::CRC_INIT : crc_ff;
      crc_next = crc32tg_pkg::crc_byte(crc_base, step.data);
      crc_in   = step.advance ? crc_next : crc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= crc32tg_pkg::CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

[sv/crc32tg_guess.sv]
// Saturating binary/text byte counters and the looks-binary compare.
module crc32tg_guess (
   input  logic                  clock,
   input  logic                  reset,
   input  crc32tg_pkg::step_type step,
   output logic                  looks_binary_next
);

   crc32tg_pkg::count_type binary_ff, binary_in, binary_base, binary_next;
   crc32tg_pkg::count_type text_ff,   text_in,   text_base,   text_next;
   logic                   is_binary;

   always_comb begin
      is_binary   = (step.data < crc32tg_pkg::TEXT_LOW) || (step.data >= crc32tg_pkg::TEXT_HIGH);
      binary_base = step.first ? '0 : binary_ff;
      text_base   = step.first ? '0 : text_ff;
      binary_next = binary_base;
      text_next   = text_base;
      if (is_binary) begin
         if (binary_base != '1) begin
            binary_next = binary_base + crc32tg_pkg::count_type'(1);
         end
      end else begin
         if (text_base != '1) begin
            text_next = text_base + crc32tg_pkg::count_type'(1);
         end
      end
      looks_binary_next = binary_next > (text_next >> crc32tg_pkg::GUESS_SHIFT);
      binary_in = step.advance ? binary_next : binary_ff;
      text_in   = step.advance ? text_next : text_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         binary_ff <= '0;
         text_ff   <= '0;
      end else begin
         binary_ff <= binary_in;
         text_ff   <= text_in;
      end
   end

endmodule
